FILE: sv/kwrq_pkg.sv
`timescale 1ns / 1ps
// package for the keyword result qualifier: sizes, codes and payload types
// no dependencies; used by every file of the block except kwrq_queue

package kwrq_pkg;

  localparam int NUM_CLASSES  = 10;
  localparam int NUM_COMMANDS = 8;
  localparam int SCORE_W      = 16;
  localparam int TICK_W       = 32;

  localparam int CLASS_W     = $clog2(NUM_CLASSES);
  localparam int CMD_W       = (NUM_COMMANDS > 1) ? $clog2(NUM_COMMANDS) : 1;
  localparam int THRESHOLD_W = 16;
  localparam int DEBOUNCE_W  = 8;
  localparam int HOLDOFF_W   = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int STATUS_W    = 3;

  localparam logic [THRESHOLD_W-1:0] CONF_THRESHOLD_RESET = THRESHOLD_W'(27853);
  localparam logic [DEBOUNCE_W-1:0]  DEBOUNCE_COUNT_RESET = DEBOUNCE_W'(2);
  localparam logic [HOLDOFF_W-1:0]   HOLDOFF_TICKS_RESET  = HOLDOFF_W'(1000);
  localparam logic [DEBOUNCE_W-1:0]  HIT_MAX              = '1;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOW_CONF = 3'd0,
    ST_REJECTED = 3'd1,
    ST_DEBOUNCE = 3'd2,
    ST_HELD_OFF = 3'd3,
    ST_FIRED    = 3'd4
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CONF_THRESHOLD = 2'd0,
    CFG_DEBOUNCE_COUNT = 2'd1,
    CFG_HOLDOFF_TICKS  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score_0;
    logic [SCORE_W-1:0] score_1;
    logic [SCORE_W-1:0] score_2;
    logic [SCORE_W-1:0] score_3;
    logic [SCORE_W-1:0] score_4;
    logic [SCORE_W-1:0] score_5;
    logic [SCORE_W-1:0] score_6;
    logic [SCORE_W-1:0] score_7;
    logic [SCORE_W-1:0] score_8;
    logic [SCORE_W-1:0] score_9;
    logic [TICK_W-1:0]  now_tick;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic [CLASS_W-1:0] best_class;
    logic               fire;
    logic [SCORE_W-1:0] confidence;
  } result_t;

  // classified transaction handed from front to back
  typedef struct packed {
    logic [CLASS_W-1:0] best_class;
    logic [SCORE_W-1:0] confidence;
    logic [TICK_W-1:0]  now_tick;
    logic               confident;
    logic               command;
  } cls_t;

endpackage

FILE: sv/kwrq_queue.sv
`timescale 1ns / 1ps
// small first-in first-out queue with full and empty flags
// depends on nothing; payload type and depth are parameters

module kwrq_queue #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: sv/kwrq_front.sv
`timescale 1ns / 1ps
// front end: argmax over the class scores and the confidence test
// depends on kwrq_pkg

module kwrq_front (
  input  kwrq_pkg::item_t                        item,
  input  logic [kwrq_pkg::THRESHOLD_W-1:0]       conf_threshold,
  output kwrq_pkg::cls_t                         cls
);

  import kwrq_pkg::*;

  localparam int LVLS   = $clog2(NUM_CLASSES);
  localparam int LEAVES = 2 ** LVLS;

  logic [SCORE_W-1:0] scores [NUM_CLASSES];
  logic [SCORE_W-1:0] t_score [LVLS+1][LEAVES];
  logic [CLASS_W-1:0] t_idx   [LVLS+1][LEAVES];

  assign scores[0] = item.score_0;
  assign scores[1] = item.score_1;
  assign scores[2] = item.score_2;
  assign scores[3] = item.score_3;
  assign scores[4] = item.score_4;
  assign scores[5] = item.score_5;
  assign scores[6] = item.score_6;
  assign scores[7] = item.score_7;
  assign scores[8] = item.score_8;
  assign scores[9] = item.score_9;

  // compare tree; left (lower index) wins ties, padding leaves score zero
  always_comb begin
    for (int l = 0; l <= LVLS; l++) begin
      for (int j = 0; j < LEAVES; j++) begin
        t_score[l][j] = '0;
        t_idx[l][j]   = CLASS_W'(j);
      end
    end
    for (int j = 0; j < NUM_CLASSES; j++) begin
      t_score[0][j] = scores[j];
    end
    for (int l = 0; l < LVLS; l++) begin
      for (int j = 0; j < LEAVES / 2; j++) begin
        if (t_score[l][2*j] >= t_score[l][2*j+1]) begin
          t_score[l+1][j] = t_score[l][2*j];
          t_idx[l+1][j]   = t_idx[l][2*j];
        end else begin
          t_score[l+1][j] = t_score[l][2*j+1];
          t_idx[l+1][j]   = t_idx[l][2*j+1];
        end
      end
    end
  end

  always_comb begin
    cls.best_class = t_idx[LVLS][0];
    cls.confidence = t_score[LVLS][0];
    cls.now_tick   = item.now_tick;
    cls.confident  = (t_score[LVLS][0] >= conf_threshold);
    cls.command    = (t_idx[LVLS][0] < CLASS_W'(NUM_COMMANDS));
  end

endmodule

FILE: sv/kwrq_back.sv
`timescale 1ns / 1ps
// back end: debounce counter, holdoff timer and result formatting
// depends on kwrq_pkg

module kwrq_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cls_valid,
  input  kwrq_pkg::cls_t                       cls,
  output logic                                 cls_pop,
  input  logic [kwrq_pkg::DEBOUNCE_W-1:0]      debounce_count,
  input  logic [kwrq_pkg::HOLDOFF_W-1:0]       holdoff_ticks,
  input  logic                                 res_full,
  output logic                                 res_push,
  output kwrq_pkg::result_t                    res
);

  import kwrq_pkg::*;

  localparam int CMP_W = (TICK_W > HOLDOFF_W) ? TICK_W : HOLDOFF_W;

  logic                  last_class_valid;
  logic [CMD_W-1:0]      last_class;
  logic [DEBOUNCE_W-1:0] hit_count;
  logic [TICK_W-1:0]     last_fire_tick;

  logic                  last_class_valid_next;
  logic [CMD_W-1:0]      last_class_next;
  logic [DEBOUNCE_W-1:0] hit_count_next;
  logic [TICK_W-1:0]     last_fire_tick_next;

  logic [TICK_W-1:0]     elapsed;
  logic                  same_cmd;
  logic [CMD_W-1:0]      cmd;

  assign cls_pop  = cls_valid && !res_full;
  assign res_push = cls_pop;
  assign cmd      = cls.best_class[CMD_W-1:0];
  assign same_cmd = last_class_valid && (last_class == cmd);
  assign elapsed  = cls.now_tick - last_fire_tick;

  always_comb begin
    last_class_valid_next = last_class_valid;
    last_class_next       = last_class;
    hit_count_next        = hit_count;
    last_fire_tick_next   = last_fire_tick;
    res.best_class        = cls.best_class;
    res.confidence        = cls.confidence;
    res.fire              = 1'b0;
    res.status            = ST_LOW_CONF;
    if (!cls.confident) begin
      res.status = ST_LOW_CONF;
    end else if (!cls.command) begin
      last_class_valid_next = 1'b0;
      last_class_next       = '0;
      hit_count_next        = '0;
      res.status            = ST_REJECTED;
    end else begin
      last_class_valid_next = 1'b1;
      last_class_next       = cmd;
      if (same_cmd) begin
        hit_count_next = (hit_count == HIT_MAX) ? hit_count
                                                : hit_count + DEBOUNCE_W'(1);
      end else begin
        hit_count_next = DEBOUNCE_W'(1);
      end
      if (hit_count_next < debounce_count) begin
        res.status = ST_DEBOUNCE;
      end else if (CMP_W'(elapsed) < CMP_W'(holdoff_ticks)) begin
        res.status = ST_HELD_OFF;
      end else begin
        last_fire_tick_next = cls.now_tick;
        res.status          = ST_FIRED;
        res.fire            = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_class_valid <= 1'b0;
      last_class       <= '0;
      hit_count        <= '0;
      last_fire_tick   <= '0;
    end else if (cls_pop) begin
      last_class_valid <= last_class_valid_next;
      last_class       <= last_class_next;
      hit_count        <= hit_count_next;
      last_fire_tick   <= last_fire_tick_next;
    end
  end

endmodule

FILE: sv/keyword_result_qualifier.sv
`timescale 1ns / 1ps
// keyword result qualifier: argmax, confidence gate, debounce and holdoff
// a result passes through the front-to-back queue and then the result queue to the ports
// throughput: one transaction per cycle while the result queue has room, set by the back end
// queues of QUEUE_DEPTH entries sit between front and back and in front of the result ports
// reset (synchronous, active high) empties both queues, drops the held command and
// returns the configuration registers to their defaults; no clearing pass is needed

module keyword_result_qualifier #(
  parameter int QUEUE_DEPTH = kwrq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // input side, looks like the write end of a queue
  input  logic                                push,
  output logic                                full,
  input  kwrq_pkg::item_t                     item,
  // result side, looks like the read end of a queue
  output logic                                empty,
  input  logic                                pop,
  output kwrq_pkg::result_t                   result,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kwrq_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [kwrq_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import kwrq_pkg::*;

  // configuration registers
  logic [THRESHOLD_W-1:0] conf_threshold;
  logic [DEBOUNCE_W-1:0]  debounce_count;
  logic [HOLDOFF_W-1:0]   holdoff_ticks;

  // front to back queue signals
  cls_t    cls_in;
  cls_t    cls_out;
  logic    cls_full;
  logic    cls_empty;
  logic    cls_pop;

  // back to result queue signals
  result_t res;
  logic    res_push;
  logic    res_full;

  // configuration writes are always taken; an unknown index is ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      conf_threshold <= CONF_THRESHOLD_RESET;
      debounce_count <= DEBOUNCE_COUNT_RESET;
      holdoff_ticks  <= HOLDOFF_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CONF_THRESHOLD: conf_threshold <= cfg_data[THRESHOLD_W-1:0];
        CFG_DEBOUNCE_COUNT: debounce_count <= cfg_data[DEBOUNCE_W-1:0];
        CFG_HOLDOFF_TICKS:  holdoff_ticks  <= cfg_data[HOLDOFF_W-1:0];
        default: ;
      endcase
    end
  end

  // front end: classifies the incoming transaction in the cycle it is taken
  kwrq_front u_front (
    .item           (item),
    .conf_threshold (conf_threshold),
    .cls            (cls_in)
  );

  // decoupling queue; input side stalls only when this fills
  kwrq_queue #(
    .T     (cls_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_cls_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cls_in),
    .full  (cls_full),
    .pop   (cls_pop),
    .rdata (cls_out),
    .empty (cls_empty)
  );

  assign full = cls_full;

  // back end: updates the held command state and builds the result
  kwrq_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cls_valid      (!cls_empty),
    .cls            (cls_out),
    .cls_pop        (cls_pop),
    .debounce_count (debounce_count),
    .holdoff_ticks  (holdoff_ticks),
    .res_full       (res_full),
    .res_push       (res_push),
    .res            (res)
  );

  // result queue; the back keeps working while a finished result waits
  kwrq_queue #(
    .T     (result_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

FILE: sv/kwrq_checker.sv
`timescale 1ns / 1ps
// port-level checks for the keyword result qualifier, bound to the top level
// depends on kwrq_pkg and keyword_result_qualifier

module kwrq_checker (
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              empty,
  input kwrq_pkg::result_t result
);

  import kwrq_pkg::*;

  // fire flag and fired status always travel together
  a_fire_status: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.fire == (result.status == ST_FIRED)))
    else $error("fire flag disagrees with status");

  // silence and unknown classes that pass the gate must be rejected
  a_reject_class: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status != ST_LOW_CONF &&
     result.best_class >= CLASS_W'(NUM_COMMANDS)) |-> result.status == ST_REJECTED)
    else $error("non-command class not rejected");

  // a command class is never reported as rejected
  a_command_kept: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.best_class < CLASS_W'(NUM_COMMANDS)) |->
      result.status != ST_REJECTED)
    else $error("command class reported as rejected");

  // winner index stays within the class count
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.best_class < CLASS_W'(NUM_CLASSES))
    else $error("best class out of range");

  // reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("queues not empty after reset");

endmodule

bind keyword_result_qualifier kwrq_checker u_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the keyword result qualifier: directed table, then random phases
// depends on kwrq_pkg (sizes, codes, payload types) and keyword_result_qualifier only

module testbench;
  import kwrq_pkg::*;

  // spare register index, writes to it must leave every register alone
  localparam logic [CFG_INDEX_W-1:0] CFG_NO_REG = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned IDLE_PCT    = 36;
  localparam int unsigned SHOW_WRONG  = 10;

  // one row of the directed table: stimulus plus an optional hand-typed expectation
  typedef struct {
    item_t   stim;
    bit      fixed;
    result_t want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   push;
  logic                   full;
  item_t                  item;
  logic                   empty;
  logic                   pop = 1'b0;
  result_t                result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // predictor copy of the registers and of the held-command state
  logic [THRESHOLD_W-1:0] thr_reg;
  logic [DEBOUNCE_W-1:0]  deb_reg;
  logic [HOLDOFF_W-1:0]   hold_reg;
  logic                   held_valid;
  logic [CMD_W-1:0]       held_cmd;
  logic [DEBOUNCE_W-1:0]  hit_run;
  logic [TICK_W-1:0]      last_fire;

  // verdicts still owed by the block, oldest first
  result_t     pending_verdicts[$];
  result_t     front;
  row_t        dir_rows[$];
  int unsigned items_taken;
  int unsigned regs_written;
  int unsigned wrong_count;
  int unsigned cycle_no;

  // driver side bookkeeping
  bit               row_fixed;
  result_t          row_want;
  bit               calm;       // no idling on either side while set
  bit               streaks;    // one command wins long runs (hit counter saturation)
  int unsigned      focus;
  int unsigned      run_left;
  logic [TICK_W-1:0] tick_now;

  keyword_result_qualifier u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // score k sits above the tick, score_0 at the top of the packed item
  function automatic int score_lsb(int k);
    return TICK_W + SCORE_W * (NUM_CLASSES - 1 - k);
  endfunction

  // argmax, confidence gate, debounce and holdoff; updates the predictor state
  function automatic result_t qualify(item_t it);
    result_t            r;
    logic [CLASS_W-1:0] win;
    logic [SCORE_W-1:0] top;
    logic [TICK_W-1:0]  elapsed;
    win = '0;
    top = it[score_lsb(0) +: SCORE_W];
    // strict greater-than keeps the lowest index on a tie
    for (int k = 1; k < NUM_CLASSES; k++) begin
      if (it[score_lsb(k) +: SCORE_W] > top) begin
        top = it[score_lsb(k) +: SCORE_W];
        win = CLASS_W'(k);
      end
    end
    r.best_class = win;
    r.confidence = top;
    r.fire       = 1'b0;
    if (top < thr_reg) begin
      // low confidence leaves the state untouched
      r.status = ST_LOW_CONF;
    end else if (win >= NUM_COMMANDS) begin
      // silence or unknown drops the held command
      held_valid = 1'b0;
      held_cmd   = '0;
      hit_run    = '0;
      r.status   = ST_REJECTED;
    end else begin
      if (held_valid && held_cmd == win[CMD_W-1:0]) begin
        if (hit_run != HIT_MAX) hit_run = hit_run + 1'b1;
      end else begin
        held_valid = 1'b1;
        held_cmd   = win[CMD_W-1:0];
        hit_run    = DEBOUNCE_W'(1);
      end
      elapsed = it.now_tick - last_fire;
      if (hit_run < deb_reg) begin
        r.status = ST_DEBOUNCE;
      end else if (elapsed < hold_reg) begin
        r.status = ST_HELD_OFF;
      end else begin
        last_fire = it.now_tick;
        r.status  = ST_FIRED;
        r.fire    = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic result_t verdict(status_t st, int unsigned bc, bit fi, logic [15:0] cf);
    result_t r;
    r.status     = st;
    r.best_class = CLASS_W'(bc);
    r.fire       = fi;
    r.confidence = cf;
    return r;
  endfunction

  // table row: every class gets base, then classes a and b are overwritten
  function automatic void add_row(int unsigned a, logic [15:0] va, int unsigned b,
                                  logic [15:0] vb, logic [15:0] base, logic [31:0] tick,
                                  bit fixed, result_t want);
    row_t row;
    row.stim = '0;
    for (int k = 0; k < NUM_CLASSES; k++) row.stim[score_lsb(k) +: SCORE_W] = base;
    row.stim[score_lsb(a) +: SCORE_W] = va;
    row.stim[score_lsb(b) +: SCORE_W] = vb;
    row.stim.now_tick = tick;
    row.fixed = fixed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // random item: mostly well-formed hits on the current focus command, plus rejected
  // classes, low-confidence items and raw noise; ticks hover around the holdoff edge
  function automatic item_t next_item();
    item_t       it;
    int unsigned r;
    int unsigned hi;
    int unsigned win;
    int unsigned top;
    it = '0;
    hi = (thr_reg > 32768) ? 65535 : 32768;
    if (run_left == 0) begin
      focus    = $urandom_range(NUM_COMMANDS - 1, 0);
      run_left = streaks ? 400 : $urandom_range(deb_reg + 3, 1);
    end
    run_left--;
    r = $urandom_range(99, 0);
    if (streaks && r >= 70) r = (r < 90) ? 0 : 85;
    if (r < 80) begin
      win = (r < 70) ? focus : $urandom_range(NUM_CLASSES - 1, NUM_COMMANDS);
      top = $urandom_range(hi, thr_reg);
      for (int k = 0; k < NUM_CLASSES; k++)
        it[score_lsb(k) +: SCORE_W] = (top == 0) ? '0 : SCORE_W'($urandom_range(top - 1, 0));
      it[score_lsb(win) +: SCORE_W] = SCORE_W'(top);
      // occasional tie on another class
      if ($urandom_range(9, 0) == 0)
        it[score_lsb($urandom_range(NUM_CLASSES - 1, 0)) +: SCORE_W] = SCORE_W'(top);
    end else if (r < 90) begin
      for (int k = 0; k < NUM_CLASSES; k++)
        it[score_lsb(k) +: SCORE_W] = (thr_reg == 0) ? '0 :
                                      SCORE_W'($urandom_range(thr_reg - 1, 0));
    end else begin
      for (int k = 0; k < NUM_CLASSES; k++) it[score_lsb(k) +: SCORE_W] = SCORE_W'($urandom());
    end
    r = $urandom_range(99, 0);
    if (r < 50) tick_now = tick_now + $urandom_range(600, 0);
    else if (r < 80) tick_now = last_fire + hold_reg + $urandom_range(2, 0) - 1;
    else tick_now = $urandom();
    it.now_tick = tick_now;
    return it;
  endfunction

  task automatic flag_wrong(string what, result_t want, result_t got);
    wrong_count++;
    if (wrong_count <= SHOW_WRONG)
      $display({"wrong result (%s): expected status %0d class %0d fire %0d conf %0d,",
                " got status %0d class %0d fire %0d conf %0d"},
               what, want.status, want.best_class, want.fire, want.confidence,
               got.status, got.best_class, got.fire, got.confidence);
  endtask

  // one transaction on the input side; push stays high into the next call
  task automatic send_item(item_t it, bit fixed, result_t want);
    int unsigned target;
    if (!calm) begin
      while ($urandom_range(99, 0) < IDLE_PCT) begin
        push <= 1'b0;
        @(negedge clk);
      end
    end
    push     <= 1'b1;
    item     <= it;
    row_fixed = fixed;
    row_want  = want;
    target    = items_taken + 1;
    do @(negedge clk); while (items_taken != target);
  endtask

  // register write; cfg_valid is lowered by the caller after the last one
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    int unsigned target;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    target     = regs_written + 1;
    do @(negedge clk); while (regs_written != target);
  endtask

  // stop sending and wait for every owed verdict
  task automatic settle();
    push <= 1'b0;
    do @(negedge clk); while (pending_verdicts.size() != 0);
  endtask

  task automatic run_phase(int unsigned n, logic [15:0] thr, logic [7:0] deb,
                           logic [31:0] hold, bit quiet, bit long_runs);
    settle();
    // upper data bits are junk and must be dropped by the narrower registers
    write_reg(CFG_CONF_THRESHOLD, {16'($urandom()), thr});
    write_reg(CFG_DEBOUNCE_COUNT, {24'($urandom()), deb});
    write_reg(CFG_HOLDOFF_TICKS, hold);
    write_reg(CFG_NO_REG, $urandom());
    cfg_valid <= 1'b0;
    calm      = quiet;
    streaks   = long_runs;
    run_left  = 0;
    for (int unsigned i = 0; i < n; i++) send_item(next_item(), 1'b0, '0);
  endtask

  // receiver: random stalls except in the calm stretch
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= calm || ($urandom_range(99, 0) >= IDLE_PCT);
    end
  end

  // everything is sampled at the rising edge: check results, track writes, predict
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (pending_verdicts.size() == 0) begin
          flag_wrong("no transaction expected", '0, result);
        end else begin
          front = pending_verdicts.pop_front();
          if (front.status !== result.status || front.best_class !== result.best_class ||
              front.fire !== result.fire || front.confidence !== result.confidence)
            flag_wrong("field differs", front, result);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CONF_THRESHOLD: thr_reg  = cfg_data[THRESHOLD_W-1:0];
          CFG_DEBOUNCE_COUNT: deb_reg  = cfg_data[DEBOUNCE_W-1:0];
          CFG_HOLDOFF_TICKS:  hold_reg = cfg_data[HOLDOFF_W-1:0];
          default: ;
        endcase
        regs_written++;
      end
      if (push && !full) begin
        // the predictor always runs so its state follows the block
        front = qualify(item);
        if (row_fixed) front = row_want;
        pending_verdicts.push_back(front);
        items_taken++;
      end
    end
  end

  // watchdog
  initial begin
    cycle_no = 0;
    while (cycle_no < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_no++;
    end
    $display("keyword_result_qualifier: mismatch");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    push         = 1'b0;
    item         = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    thr_reg      = CONF_THRESHOLD_RESET;
    deb_reg      = DEBOUNCE_COUNT_RESET;
    hold_reg     = HOLDOFF_TICKS_RESET;
    held_valid   = 1'b0;
    held_cmd     = '0;
    hit_run      = '0;
    last_fire    = '0;
    items_taken  = 0;
    regs_written = 0;
    wrong_count  = 0;
    row_fixed    = 1'b0;
    row_want     = '0;
    calm         = 1'b0;
    streaks      = 1'b0;
    run_left     = 0;
    tick_now     = '0;

    // directed table, run on the reset register values
    // all zero scores: class 0 wins with nothing
    add_row(0, 16'd0, 0, 16'd0, 16'd0, 32'd0, 1, verdict(ST_LOW_CONF, 0, 0, 16'd0));
    // every class at 1.0: lowest index wins, first hit debounces
    add_row(0, 16'd32768, 0, 16'd32768, 16'd32768, 32'd5, 1,
            verdict(ST_DEBOUNCE, 0, 0, 16'd32768));
    // second hit, but the first firing after reset also needs the holdoff from tick zero
    add_row(0, 16'd32768, 0, 16'd32768, 16'd32768, 32'd10, 1,
            verdict(ST_HELD_OFF, 0, 0, 16'd32768));
    add_row(3, 16'd32768, 3, 16'd32768, 16'd0, 32'd2000, 1,
            verdict(ST_DEBOUNCE, 3, 0, 16'd32768));
    add_row(3, 16'd32768, 3, 16'd32768, 16'd0, 32'd2001, 1,
            verdict(ST_FIRED, 3, 1, 16'd32768));
    // continued hits are held off, then fire again exactly at the holdoff
    add_row(3, 16'd32768, 3, 16'd32768, 16'd0, 32'd2500, 1,
            verdict(ST_HELD_OFF, 3, 0, 16'd32768));
    add_row(3, 16'd32768, 3, 16'd32768, 16'd0, 32'd3001, 1,
            verdict(ST_FIRED, 3, 1, 16'd32768));
    // silence, then unknown at full scale: held command cleared
    add_row(8, 16'd40000, 8, 16'd40000, 16'd0, 32'd3100, 1,
            verdict(ST_REJECTED, 8, 0, 16'd40000));
    add_row(9, 16'hFFFF, 3, 16'hFFFE, 16'd0, 32'd3200, 1,
            verdict(ST_REJECTED, 9, 0, 16'hFFFF));
    // same command as before the reject counts as new
    add_row(3, 16'd32768, 3, 16'd32768, 16'd0, 32'd4100, 1,
            verdict(ST_DEBOUNCE, 3, 0, 16'd32768));
    // threshold edge, one below and exactly on it
    add_row(7, 16'd27852, 7, 16'd27852, 16'd0, 32'd4200, 1,
            verdict(ST_LOW_CONF, 7, 0, 16'd27852));
    add_row(7, 16'd27853, 7, 16'd27853, 16'd0, 32'd4300, 1,
            verdict(ST_DEBOUNCE, 7, 0, 16'd27853));
    // tie between two commands
    add_row(2, 16'd30000, 5, 16'd30000, 16'd0, 32'd4400, 1,
            verdict(ST_DEBOUNCE, 2, 0, 16'd30000));
    // low confidence in the middle of a run keeps the count
    add_row(2, 16'd100, 2, 16'd100, 16'd0, 32'd4500, 1, verdict(ST_LOW_CONF, 2, 0, 16'd100));
    add_row(2, 16'd30000, 2, 16'd30000, 16'd0, 32'd3900, 1,
            verdict(ST_HELD_OFF, 2, 0, 16'd30000));
    // tick wrap: fire near the top, then measure across zero
    add_row(2, 16'd30000, 2, 16'd30000, 16'd0, 32'hFFFF_FF00, 1,
            verdict(ST_FIRED, 2, 1, 16'd30000));
    add_row(2, 16'd30000, 2, 16'd30000, 16'd0, 32'h0000_0010, 1,
            verdict(ST_HELD_OFF, 2, 0, 16'd30000));
    add_row(2, 16'd30000, 2, 16'd30000, 16'd0, 32'h0000_0300, 1,
            verdict(ST_FIRED, 2, 1, 16'd30000));
    // score above 1.0 compared as plain unsigned
    add_row(1, 16'd32769, 0, 16'd32768, 16'd0, 32'h0000_0400, 1,
            verdict(ST_DEBOUNCE, 1, 0, 16'd32769));
    // alternating bit patterns, left to the predictor
    add_row(6, 16'hAAAA, 6, 16'hAAAA, 16'h5555, 32'hAAAA_AAAA, 0, '0);
    add_row(0, 16'hFFFF, 0, 16'hFFFF, 16'hAAAA, 32'h5555_5555, 0, '0);
    add_row(4, 16'h5555, 9, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 0, '0);

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].stim, dir_rows[i].fixed, dir_rows[i].want);

    // random phases, each begins with a full drain before the register writes
    run_phase(140, 16'd27853, 8'd2, 32'd1000, 0, 0);
    // everything passes, zero debounce, no holdoff; no idling anywhere here
    run_phase(120, 16'd0, 8'd0, 32'd0, 1, 0);
    // long runs of one command to saturate the hit counter at the top debounce
    run_phase(300, 16'd32768, 8'd255, 32'd50, 0, 1);
    // only full-scale scores pass, holdoff at its maximum
    run_phase(40, 16'hFFFF, 8'd1, 32'hFFFF_FFFF, 0, 0);
    run_phase(150, 16'($urandom_range(32768, 0)), 8'($urandom_range(8, 1)),
              32'($urandom_range(3000, 0)), 0, 0);

    settle();
    calm = 1'b0;
    // a stray result would show up during this wait
    repeat (8) @(negedge clk);
    if (wrong_count == 0 && pending_verdicts.size() == 0) begin
      $display("keyword_result_qualifier: match");
    end else begin
      $display("keyword_result_qualifier: mismatch");
    end
    $finish;
  end

endmodule
